[design/offr_pkg.sv]
package offr_pkg;

  // Frame layout.
  localparam int unsigned FrameLen = 14;
  localparam logic [7:0]  Hdr0     = 8'hFE;
  localparam logic [7:0]  Hdr1     = 8'h0A;

  // Byte positions within a frame.
  localparam logic [3:0] PosHdr0   = 4'd0;
  localparam logic [3:0] PosHdr1   = 4'd1;
  localparam logic [3:0] PosFlowXL = 4'd2;
  localparam logic [3:0] PosFlowXH = 4'd3;
  localparam logic [3:0] PosFlowYL = 4'd4;
  localparam logic [3:0] PosFlowYH = 4'd5;
  localparam logic [3:0] PosTimeL  = 4'd6;
  localparam logic [3:0] PosTimeH  = 4'd7;
  localparam logic [3:0] PosQual   = 4'd10;
  localparam logic [3:0] PosXorEnd = 4'd11;
  localparam logic [3:0] PosCheck  = 4'd12;
  localparam logic [3:0] PosLast   = 4'd13;

  localparam int unsigned TimerBits = 24;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_COLLECT_TIMEOUT = 1'b0,
    REG_REQUEST_PERIOD  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_HEADER   = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [15:0]        integration_time;
    logic [7:0]         quality;
    logic [15:0]        error_total;
    logic [15:0]        timeout_total;
  } out_item_t;

endpackage

[design/optical_flow_frame_receiver.sv]
// Optical flow frame receiver.
//
// The input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
// received serial byte or per time tick, selected by the cmd field. The
// output channel (out_valid_o / out_stall_i / out_data_o) carries one beat per
// finished frame check or collect timeout: status, flow X/Y, integration time,
// quality and the two saturating event totals.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the collect
// timeout and the request period; it is always ready.
//
// Each input beat is handled in the cycle it is accepted, and the result, if
// any, appears in the output register on the next cycle. One beat
// is accepted every cycle as long as the output register is empty or is being
// drained in the same cycle, so throughput is one item per cycle.
// When the receiver stalls with a result pending, in_stall_o rises and the
// block holds until that result is taken.
// Reset leaves the block waiting with a zero countdown, so the first tick
// opens collection; the totals clear and the timers take their defaults.
module optical_flow_frame_receiver
  import offr_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [TimerBits-1:0] cfg_data_i
);

  localparam logic [COUNTER_BITS-1:0] CntOne = COUNTER_BITS'(1);

  // Configuration registers.
  logic [TimerBits-1:0] collect_to_q, request_per_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collect_to_q  <= TimerBits'(33333);
      request_per_q <= TimerBits'(100000);
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_COLLECT_TIMEOUT: collect_to_q  <= cfg_data_i;
        REG_REQUEST_PERIOD:  request_per_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state. Only the bytes that reach the result are kept; the header
  // and the checksum are folded into flags as their bytes arrive.
  logic                    collecting_q, collecting_d;
  logic [TimerBits-1:0]    countdown_q, countdown_d;
  logic [3:0]              byte_cnt_q, byte_cnt_d;
  logic [COUNTER_BITS-1:0] err_cnt_q, err_cnt_d;
  logic [COUNTER_BITS-1:0] to_cnt_q, to_cnt_d;
  logic                    hdr_ok_q, hdr_ok_d;
  logic                    chk_ok_q, chk_ok_d;
  logic [7:0]              xor_q, xor_d;
  logic [15:0]             flow_x_q, flow_x_d;
  logic [15:0]             flow_y_q, flow_y_d;
  logic [15:0]             itime_q, itime_d;
  logic [7:0]              qual_q, qual_d;

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      emit;
  logic      accept;

  // A new beat may enter whenever the result register is free or is being
  // emptied in this very cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  logic [31:0] err_ext, to_ext;
  assign err_ext = 32'(err_cnt_q);
  assign to_ext  = 32'(to_cnt_q);

  always_comb begin
    logic [7:0]              b;
    logic [COUNTER_BITS-1:0] err_inc, to_inc;

    b       = in_data_i.rx_byte;
    err_inc = (err_cnt_q != '1) ? err_cnt_q + CntOne : err_cnt_q;
    to_inc  = (to_cnt_q != '1) ? to_cnt_q + CntOne : to_cnt_q;

    collecting_d = collecting_q;
    countdown_d  = countdown_q;
    byte_cnt_d   = byte_cnt_q;
    err_cnt_d    = err_cnt_q;
    to_cnt_d     = to_cnt_q;
    hdr_ok_d     = hdr_ok_q;
    chk_ok_d     = chk_ok_q;
    xor_d        = xor_q;
    flow_x_d     = flow_x_q;
    flow_y_d     = flow_y_q;
    itime_d      = itime_q;
    qual_d       = qual_q;
    emit         = 1'b0;

    out_d                  = '0;
    out_d.flow_x           = '0;
    out_d.error_total      = err_ext[15:0];
    out_d.timeout_total    = to_ext[15:0];

    if (in_data_i.cmd == CMD_TICK) begin
      if (!collecting_q) begin
        if (countdown_q == '0) begin
          collecting_d = 1'b1;
          byte_cnt_d   = '0;
          countdown_d  = collect_to_q;
        end else begin
          countdown_d = countdown_q - TimerBits'(1);
        end
      end else if (countdown_q[TimerBits-1:1] == '0) begin
        // Collect timer ran out: report and reopen collection.
        to_cnt_d            = to_inc;
        byte_cnt_d          = '0;
        countdown_d         = collect_to_q;
        emit                = 1'b1;
        out_d.status        = ST_TIMEOUT;
        out_d.timeout_total = 16'(32'(to_inc));
      end else begin
        countdown_d = countdown_q - TimerBits'(1);
      end
    end else if (collecting_q) begin
      byte_cnt_d = byte_cnt_q + 4'd1;
      unique case (byte_cnt_q)
        PosHdr0:   hdr_ok_d = (b == Hdr0);
        PosHdr1:   hdr_ok_d = hdr_ok_q && (b == Hdr1);
        PosFlowXL: flow_x_d[7:0]  = b;
        PosFlowXH: flow_x_d[15:8] = b;
        PosFlowYL: flow_y_d[7:0]  = b;
        PosFlowYH: flow_y_d[15:8] = b;
        PosTimeL:  itime_d[7:0]   = b;
        PosTimeH:  itime_d[15:8]  = b;
        PosQual:   qual_d         = b;
        PosCheck:  chk_ok_d       = (xor_q == b);
        default: ;
      endcase
      // Running XOR over the payload bytes.
      if (byte_cnt_q == PosFlowXL) begin
        xor_d = b;
      end else if (byte_cnt_q > PosFlowXL && byte_cnt_q <= PosXorEnd) begin
        xor_d = xor_q ^ b;
      end

      if (byte_cnt_q == PosLast) begin
        emit       = 1'b1;
        byte_cnt_d = '0;
        if (!hdr_ok_q || !chk_ok_q) begin
          err_cnt_d         = err_inc;
          countdown_d       = collect_to_q;
          out_d.status      = hdr_ok_q ? ST_CHECKSUM : ST_HEADER;
          out_d.error_total = 16'(32'(err_inc));
        end else begin
          collecting_d           = 1'b0;
          countdown_d            = request_per_q;
          out_d.status           = ST_GOOD;
          out_d.flow_x           = flow_x_q;
          out_d.flow_y           = flow_y_q;
          out_d.integration_time = itime_q;
          out_d.quality          = qual_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      countdown_q  <= '0;
      byte_cnt_q   <= '0;
      err_cnt_q    <= '0;
      to_cnt_q     <= '0;
      hdr_ok_q     <= 1'b0;
      chk_ok_q     <= 1'b0;
      xor_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        collecting_q <= collecting_d;
        countdown_q  <= countdown_d;
        byte_cnt_q   <= byte_cnt_d;
        err_cnt_q    <= err_cnt_d;
        to_cnt_q     <= to_cnt_d;
        hdr_ok_q     <= hdr_ok_d;
        chk_ok_q     <= chk_ok_d;
        xor_q        <= xor_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flow_x_q <= flow_x_d;
      flow_y_q <= flow_y_d;
      itime_q  <= itime_d;
      qual_q   <= qual_d;
    end
    if (accept && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
